@@ rtl/core/radix2_twiddle_butterfly_top_macros.svh @@
// ----------------------------------------------------------------------------
// radix2 twiddle butterfly assertion macros
// shared property wrappers for the butterfly core checks
// ----------------------------------------------------------------------------
`ifndef RADIX2_TWIDDLE_BUTTERFLY_TOP_MACROS_SVH
`define RADIX2_TWIDDLE_BUTTERFLY_TOP_MACROS_SVH

// same-cycle implication
`define R2TB_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("r2tb check failed");

// next-cycle implication
`define R2TB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("r2tb check failed");

`endif

@@ rtl/core/r2tb_pkg.sv @@
// ----------------------------------------------------------------------------
// r2tb_pkg
// shared types, register codes and pipeline constants of the butterfly core
// ----------------------------------------------------------------------------
package r2tb_pkg;

   localparam int TWIDDLE_DEPTH_DEF = 32768;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int TW_BITS           = 16;

   localparam int BLOCK_BITS  = 8;
   localparam int PAIR_BITS   = 15;
   localparam int PPB_BITS    = 16;
   localparam int STAGE_BITS  = 4;
   localparam int GROUP_BITS  = 16;
   localparam int LEN_BITS    = 17;
   localparam int INCR_BITS   = 16;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // block number times pairs per block
   localparam int ID_BITS   = BLOCK_BITS + PPB_BITS;
   // group count shifted by the largest stage
   localparam int MOD_BITS  = GROUP_BITS + (1 << STAGE_BITS) - 1;
   localparam int DIV_STEPS = ID_BITS;

   localparam int IDX_LAT   = 1 + DIV_STEPS + 3;
   localparam int ROM_LAT   = 1;
   localparam int BF_LAT    = 3;
   localparam int TOTAL_LAT = IDX_LAT + ROM_LAT + BF_LAT;

   typedef enum logic [1:0] {
      REG_PAIRS  = 2'd0,
      REG_STAGE  = 2'd1,
      REG_GROUPS = 2'd2,
      REG_LEN    = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [PPB_BITS-1:0]   pairs_per_block;
      logic [STAGE_BITS-1:0] stage;
      logic [GROUP_BITS-1:0] group_count;
      logic [LEN_BITS-1:0]   transform_len;
   } cfg_type;

endpackage

@@ rtl/core/r2tb_csr.sv @@
// ----------------------------------------------------------------------------
// r2tb_csr
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module r2tb_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [r2tb_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [r2tb_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [r2tb_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready,
   output r2tb_pkg::cfg_type                     cfg
);

   r2tb_pkg::cfg_type     cfg_ff;
   r2tb_pkg::cfg_type     cfg_in;
   r2tb_pkg::csr_reg_type reg_sel;
   logic                  wr_en;

   assign reg_sel = r2tb_pkg::csr_reg_type'(paddr[r2tb_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            r2tb_pkg::REG_PAIRS: begin
               cfg_in.pairs_per_block = pwdata[r2tb_pkg::PPB_BITS-1:0];
            end
            r2tb_pkg::REG_STAGE: begin
               cfg_in.stage = pwdata[r2tb_pkg::STAGE_BITS-1:0];
            end
            r2tb_pkg::REG_GROUPS: begin
               cfg_in.group_count = pwdata[r2tb_pkg::GROUP_BITS-1:0];
            end
            r2tb_pkg::REG_LEN: begin
               cfg_in.transform_len = pwdata[r2tb_pkg::LEN_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         r2tb_pkg::REG_PAIRS: begin
            prdata = r2tb_pkg::CSR_DATA_BITS'(cfg_ff.pairs_per_block);
         end
         r2tb_pkg::REG_STAGE: begin
            prdata = r2tb_pkg::CSR_DATA_BITS'(cfg_ff.stage);
         end
         r2tb_pkg::REG_GROUPS: begin
            prdata = r2tb_pkg::CSR_DATA_BITS'(cfg_ff.group_count);
         end
         r2tb_pkg::REG_LEN: begin
            prdata = r2tb_pkg::CSR_DATA_BITS'(cfg_ff.transform_len);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pairs_per_block <= r2tb_pkg::PPB_BITS'(1);
         cfg_ff.stage           <= '0;
         cfg_ff.group_count     <= r2tb_pkg::GROUP_BITS'(2);
         cfg_ff.transform_len   <= r2tb_pkg::LEN_BITS'(4096);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/r2tb_index.sv @@
// ----------------------------------------------------------------------------
// r2tb_index
// twiddle address pipeline: block offset modulo, stride product, rom wrap
// ----------------------------------------------------------------------------
module r2tb_index #(
   parameter int TWIDDLE_DEPTH = r2tb_pkg::TWIDDLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  r2tb_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   input  logic [r2tb_pkg::BLOCK_BITS-1:0]     in_block_index,
   input  logic [r2tb_pkg::PAIR_BITS-1:0]      in_pair_index,
   output logic                                out_valid,
   output logic [$clog2(TWIDDLE_DEPTH)-1:0]    out_addr
);

   localparam int ADDR_BITS = $clog2(TWIDDLE_DEPTH);
   localparam int ID_BITS   = r2tb_pkg::ID_BITS;
   localparam int MOD_BITS  = r2tb_pkg::MOD_BITS;
   localparam int STEPS     = r2tb_pkg::DIV_STEPS;
   localparam int IB        = r2tb_pkg::INCR_BITS;
   localparam int RECIP_BITS = 34 - $clog2(TWIDDLE_DEPTH);
   localparam int QP_BITS   = IB + RECIP_BITS;
   localparam longint unsigned RECIP =
      ((64'd1 << 32) + 64'(TWIDDLE_DEPTH) - 64'd1) / 64'(TWIDDLE_DEPTH);
   localparam logic [IB-1:0] DEPTH_W = IB'(TWIDDLE_DEPTH);

   logic [MOD_BITS-1:0]            modulus;
   logic [STEPS:0]                 dv_ff;
   logic [ID_BITS-1:0]             rem_ff  [STEPS+1];
   logic [ID_BITS-1:0]             idsh_ff [STEPS+1];
   logic [r2tb_pkg::PAIR_BITS-1:0] k_ff    [STEPS+1];
   logic [ID_BITS-1:0]             rem_in  [STEPS+1];

   logic [ID_BITS-1:0]             m_val;
   logic [IB-1:0]                  sum_w;
   logic [IB-1:0]                  incr_w;
   logic [IB-1:0]                  prod_in;
   logic [IB-1:0]                  prod_ff;
   logic                           pv_ff;
   logic [IB-1:0]                  q_in;
   logic [IB-1:0]                  q_ff;
   logic [IB-1:0]                  prod2_ff;
   logic                           qv_ff;
   logic [ADDR_BITS-1:0]           addr_in;
   logic [ADDR_BITS-1:0]           addr_ff;
   logic                           av_ff;

   assign modulus = MOD_BITS'(cfg.group_count) << cfg.stage;

   // restoring remainder, one dividend bit per stage
   always_comb begin
      logic [ID_BITS:0] t;
      rem_in[0] = '0;
      for (int j = 0; j < STEPS; j++) begin
         t = {rem_ff[j], idsh_ff[j][ID_BITS-1]};
         if (MOD_BITS'(t) >= modulus) begin
            rem_in[j+1] = ID_BITS'(t - (ID_BITS+1)'(modulus));
         end else begin
            rem_in[j+1] = ID_BITS'(t);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      idsh_ff[0] <= ID_BITS'(in_block_index) * ID_BITS'(cfg.pairs_per_block);
      k_ff[0]    <= in_pair_index;
      for (int j = 0; j < STEPS; j++) begin
         rem_ff[j+1]  <= rem_in[j+1];
         idsh_ff[j+1] <= idsh_ff[j] << 1;
         k_ff[j+1]    <= k_ff[j];
      end
   end

   always_comb begin
      m_val   = (modulus == '0) ? '0 : rem_ff[STEPS];
      sum_w   = IB'(m_val) + IB'(k_ff[STEPS]);
      incr_w  = IB'(cfg.transform_len >> (5'(cfg.stage) + 5'd1));
      prod_in = IB'(sum_w * incr_w);
      q_in    = IB'((QP_BITS'(prod_ff) * QP_BITS'(RECIP)) >> 32);
      addr_in = ADDR_BITS'(prod2_ff - IB'(q_ff * DEPTH_W));
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      prod2_ff <= prod_ff;
      addr_ff  <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         pv_ff <= 1'b0;
         qv_ff <= 1'b0;
         av_ff <= 1'b0;
      end else begin
         dv_ff <= {dv_ff[STEPS-1:0], in_valid};
         pv_ff <= dv_ff[STEPS];
         qv_ff <= pv_ff;
         av_ff <= qv_ff;
      end
   end

   assign out_valid = av_ff;
   assign out_addr  = addr_ff;

endmodule

@@ rtl/core/r2tb_rom.sv @@
// ----------------------------------------------------------------------------
// r2tb_rom
// twiddle rom with fixed contents and a registered read port
// ----------------------------------------------------------------------------
module r2tb_rom #(
   parameter int TWIDDLE_DEPTH = r2tb_pkg::TWIDDLE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_valid,
   input  logic [$clog2(TWIDDLE_DEPTH)-1:0]       rd_addr,
   output logic                                   out_valid,
   output logic signed [r2tb_pkg::TW_BITS-1:0]    out_w_re,
   output logic signed [r2tb_pkg::TW_BITS-1:0]    out_w_im
);

   localparam int TW = r2tb_pkg::TW_BITS;
   localparam logic [63:0] ONE_Q60    = 64'd1 << 60;
   localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

   // (a*b) >> 60
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // quotient by shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int j = 63; j >= 0; j--) begin
         r = {r[63:0], n[j]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[j] = 1'b1;
         end
      end
      return q;
   endfunction

   // cos and sin in q60 of 2*pi*u/65536, u up to an eighth turn
   function automatic logic [127:0] taylor(input logic [63:0] u);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] tc;
      logic [63:0] ts;
      logic [63:0] sc;
      logic [63:0] ss;
      logic [63:0] dc;
      logic [63:0] ds;
      x  = u * (TWO_PI_Q60 >> 16) + ((u * (TWO_PI_Q60 & 64'hFFFF)) >> 16);
      x2 = qmul(x, x);
      tc = ONE_Q60;
      ts = x;
      sc = tc;
      ss = ts;
      for (int k = 1; k <= 12; k++) begin
         dc = 64'((2 * k - 1) * (2 * k));
         ds = 64'((2 * k) * (2 * k + 1));
         tc = udiv64(qmul(tc, x2), dc);
         ts = udiv64(qmul(ts, x2), ds);
         if ((k % 2) == 1) begin
            sc = sc - tc;
            ss = ss - ts;
         end else begin
            sc = sc + tc;
            ss = ss + ts;
         end
      end
      return {sc, ss};
   endfunction

   function automatic logic [127:0] quarter(input logic [63:0] u);
      logic [127:0] cs;
      if (u <= 64'd8192) begin
         cs = taylor(u);
      end else begin
         cs = taylor(64'd16384 - u);
         cs = {cs[63:0], cs[127:64]};
      end
      return cs;
   endfunction

   function automatic logic [TW-1:0] scale_round(input logic [63:0] mag, input logic neg);
      logic [63:0]        m44;
      logic [63:0]        v;
      logic signed [31:0] sv;
      m44 = mag >> 16;
      v   = (64'd65537 * m44 + (64'd1 << 44)) >> 45;
      sv  = signed'(32'(v));
      if (neg) begin
         sv = -sv;
      end
      if (sv > 32'sd32767) begin
         sv = 32'sd32767;
      end
      if (sv < -32'sd32768) begin
         sv = -32'sd32768;
      end
      return TW'(sv);
   endfunction

   function automatic logic [2*TW-1:0] twiddle_entry(input int i);
      logic [127:0] cs;
      logic         cneg;
      if (i <= 16384) begin
         cs   = quarter(64'(i));
         cneg = 1'b0;
      end else begin
         cs   = quarter(64'(32768 - i));
         cneg = 1'b1;
      end
      return {scale_round(cs[127:64], cneg), scale_round(cs[63:0], 1'b1)};
   endfunction

   logic [2*TW-1:0] rom_mem [TWIDDLE_DEPTH];
   logic [2*TW-1:0] rd_data_ff;
   logic            rv_ff;

   // fixed table contents, loaded before the first clock
   initial begin
      for (int i = 0; i < TWIDDLE_DEPTH; i++) begin
         rom_mem[i] = twiddle_entry(i);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rd_valid;
      end
   end

   assign out_valid = rv_ff;
   assign out_w_re  = signed'(rd_data_ff[2*TW-1:TW]);
   assign out_w_im  = signed'(rd_data_ff[TW-1:0]);

endmodule

@@ rtl/core/r2tb_bfly.sv @@
// ----------------------------------------------------------------------------
// r2tb_bfly
// complex twiddle multiply and halved sum and difference, three stages
// ----------------------------------------------------------------------------
module r2tb_bfly #(
   parameter int SAMPLE_BITS = r2tb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [SAMPLE_BITS-1:0]         in_a_re,
   input  logic signed [SAMPLE_BITS-1:0]         in_a_im,
   input  logic signed [SAMPLE_BITS-1:0]         in_b_re,
   input  logic signed [SAMPLE_BITS-1:0]         in_b_im,
   input  logic signed [r2tb_pkg::TW_BITS-1:0]   in_w_re,
   input  logic signed [r2tb_pkg::TW_BITS-1:0]   in_w_im,
   output logic                                  out_valid,
   output logic signed [SAMPLE_BITS-1:0]         out_sum_re,
   output logic signed [SAMPLE_BITS-1:0]         out_sum_im,
   output logic signed [SAMPLE_BITS-1:0]         out_diff_re,
   output logic signed [SAMPLE_BITS-1:0]         out_diff_im
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + r2tb_pkg::TW_BITS;

   logic signed [PW-1:0] prr_ff;
   logic signed [PW-1:0] pii_ff;
   logic signed [PW-1:0] pri_ff;
   logic signed [PW-1:0] pir_ff;
   logic signed [SB-1:0] ar1_ff;
   logic signed [SB-1:0] ai1_ff;
   logic signed [PW:0]   sr_w;
   logic signed [PW:0]   si_w;
   logic signed [SB-1:0] pr_ff;
   logic signed [SB-1:0] pi_ff;
   logic signed [SB-1:0] ar2_ff;
   logic signed [SB-1:0] ai2_ff;
   logic signed [SB:0]   s_re;
   logic signed [SB:0]   s_im;
   logic signed [SB:0]   d_re;
   logic signed [SB:0]   d_im;
   logic signed [SB-1:0] sum_re_ff;
   logic signed [SB-1:0] sum_im_ff;
   logic signed [SB-1:0] diff_re_ff;
   logic signed [SB-1:0] diff_im_ff;
   logic [2:0]           v_ff;

   always_ff @(posedge clock) begin
      prr_ff <= PW'(in_b_re) * PW'(in_w_re);
      pii_ff <= PW'(in_b_im) * PW'(in_w_im);
      pri_ff <= PW'(in_b_re) * PW'(in_w_im);
      pir_ff <= PW'(in_b_im) * PW'(in_w_re);
      ar1_ff <= in_a_re;
      ai1_ff <= in_a_im;
   end

   // shift by 15 and wrap to sample width
   always_comb begin
      sr_w = (PW+1)'(prr_ff) - (PW+1)'(pii_ff);
      si_w = (PW+1)'(pri_ff) + (PW+1)'(pir_ff);
   end

   always_ff @(posedge clock) begin
      pr_ff  <= signed'(sr_w[SB+14:15]);
      pi_ff  <= signed'(si_w[SB+14:15]);
      ar2_ff <= ar1_ff;
      ai2_ff <= ai1_ff;
   end

   always_comb begin
      s_re = (SB+1)'(ar2_ff) + (SB+1)'(pr_ff);
      s_im = (SB+1)'(ai2_ff) + (SB+1)'(pi_ff);
      d_re = (SB+1)'(ar2_ff) - (SB+1)'(pr_ff);
      d_im = (SB+1)'(ai2_ff) - (SB+1)'(pi_ff);
   end

   always_ff @(posedge clock) begin
      sum_re_ff  <= signed'(s_re[SB:1]);
      sum_im_ff  <= signed'(s_im[SB:1]);
      diff_re_ff <= signed'(d_re[SB:1]);
      diff_im_ff <= signed'(d_im[SB:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   assign out_valid   = v_ff[2];
   assign out_sum_re  = sum_re_ff;
   assign out_sum_im  = sum_im_ff;
   assign out_diff_re = diff_re_ff;
   assign out_diff_im = diff_im_ff;

endmodule

@@ rtl/core/radix2_twiddle_butterfly_top.sv @@
// ----------------------------------------------------------------------------
// radix2_twiddle_butterfly_top
// radix-2 q15 butterfly with twiddle address generation and twiddle rom
// ----------------------------------------------------------------------------
// One request is taken per clock: busy is high only during reset and the
// cycle after it, so start may be held high every cycle. Each request gives
// one result on rsp_valid, in request order, shown for a single cycle with
// no way to hold it. A request passes the twiddle address pipeline (a setup
// register, 24 one-bit remainder steps for the block offset, the stride
// product and the quotient and address registers of the rom wrap), the
// registered rom read and three butterfly stages. The rom contents are fixed
// at build time and need no fill after reset. Registers are to be written
// by the user only while no request is in flight, which is not enforced.
// ----------------------------------------------------------------------------
`include "radix2_twiddle_butterfly_top_macros.svh"

module radix2_twiddle_butterfly_top #(
   parameter int TWIDDLE_DEPTH = r2tb_pkg::TWIDDLE_DEPTH_DEF,
   parameter int SAMPLE_BITS   = r2tb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [r2tb_pkg::BLOCK_BITS-1:0]       req_block_index,
   input  logic [r2tb_pkg::PAIR_BITS-1:0]        req_pair_index,
   input  logic signed [SAMPLE_BITS-1:0]         req_a_re,
   input  logic signed [SAMPLE_BITS-1:0]         req_a_im,
   input  logic signed [SAMPLE_BITS-1:0]         req_b_re,
   input  logic signed [SAMPLE_BITS-1:0]         req_b_im,
   output logic                                  rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sum_re,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sum_im,
   output logic signed [SAMPLE_BITS-1:0]         rsp_diff_re,
   output logic signed [SAMPLE_BITS-1:0]         rsp_diff_im,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [r2tb_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [r2tb_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [r2tb_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);

   localparam int SB        = SAMPLE_BITS;
   localparam int ADDR_BITS = $clog2(TWIDDLE_DEPTH);
   localparam int DLY_DEPTH = r2tb_pkg::IDX_LAT + r2tb_pkg::ROM_LAT;
   localparam int RSP_LAT   = r2tb_pkg::TOTAL_LAT;

   r2tb_pkg::cfg_type                    cfg;
   logic                                 busy_ff;
   logic                                 accept;
   logic                                 idx_valid;
   logic [ADDR_BITS-1:0]                 idx_addr;
   logic                                 rom_valid;
   logic signed [r2tb_pkg::TW_BITS-1:0]  w_re;
   logic signed [r2tb_pkg::TW_BITS-1:0]  w_im;
   logic [4*SB-1:0]                      smp_ff [DLY_DEPTH];
   logic [DLY_DEPTH-1:0]                 dv_ff;
   logic [4*SB-1:0]                      smp_out;

   assign accept  = start && !busy_ff;
   assign busy    = busy_ff;
   assign smp_out = smp_ff[DLY_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         dv_ff   <= '0;
      end else begin
         busy_ff <= 1'b0;
         dv_ff   <= {dv_ff[DLY_DEPTH-2:0], accept};
      end
   end

   // sample delay matching the address pipeline and rom read
   always_ff @(posedge clock) begin
      smp_ff[0] <= {req_a_re, req_a_im, req_b_re, req_b_im};
      for (int i = 1; i < DLY_DEPTH; i++) begin
         smp_ff[i] <= smp_ff[i-1];
      end
   end

   r2tb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   r2tb_index #(
      .TWIDDLE_DEPTH (TWIDDLE_DEPTH)
   ) u_index (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (accept),
      .in_block_index (req_block_index),
      .in_pair_index  (req_pair_index),
      .out_valid      (idx_valid),
      .out_addr       (idx_addr)
   );

   r2tb_rom #(
      .TWIDDLE_DEPTH (TWIDDLE_DEPTH)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .rd_valid  (idx_valid),
      .rd_addr   (idx_addr),
      .out_valid (rom_valid),
      .out_w_re  (w_re),
      .out_w_im  (w_im)
   );

   r2tb_bfly #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_bfly (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rom_valid),
      .in_a_re     (signed'(smp_out[4*SB-1:3*SB])),
      .in_a_im     (signed'(smp_out[3*SB-1:2*SB])),
      .in_b_re     (signed'(smp_out[2*SB-1:SB])),
      .in_b_im     (signed'(smp_out[SB-1:0])),
      .in_w_re     (w_re),
      .in_w_im     (w_im),
      .out_valid   (rsp_valid),
      .out_sum_re  (rsp_sum_re),
      .out_sum_im  (rsp_sum_im),
      .out_diff_re (rsp_diff_re),
      .out_diff_im (rsp_diff_im)
   );

   `R2TB_ASSERT_IMPL(a_rsp_from_request, clock, reset, rsp_valid, $past(accept, RSP_LAT))
   `R2TB_ASSERT_IMPL(a_rom_has_samples, clock, reset, rom_valid, dv_ff[DLY_DEPTH-1])
   `R2TB_ASSERT_IMPL(a_samples_have_rom, clock, reset, dv_ff[DLY_DEPTH-1], rom_valid)
   `R2TB_ASSERT_NEXT(a_addr_to_rom, clock, reset, idx_valid, rom_valid)

endmodule

@@ test/radix2_twiddle_butterfly_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_twiddle_butterfly_top_tb
// drives q15 butterfly requests under several register settings and idle
// patterns, predicts each result with its own twiddle series and index rule,
// and compares every rsp_valid result field by field in request order
// ----------------------------------------------------------------------------
module radix2_twiddle_butterfly_top_tb;

   localparam int BLOCK_BITS    = r2tb_pkg::BLOCK_BITS;
   localparam int PAIR_BITS     = r2tb_pkg::PAIR_BITS;
   localparam int TW_BITS       = r2tb_pkg::TW_BITS;
   localparam int PPB_BITS      = r2tb_pkg::PPB_BITS;
   localparam int STAGE_BITS    = r2tb_pkg::STAGE_BITS;
   localparam int GROUP_BITS    = r2tb_pkg::GROUP_BITS;
   localparam int LEN_BITS      = r2tb_pkg::LEN_BITS;
   localparam int CSR_ADDR_BITS = r2tb_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = r2tb_pkg::CSR_DATA_BITS;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

   typedef struct {
      logic [BLOCK_BITS-1:0]      block_index;
      logic [PAIR_BITS-1:0]       pair_index;
      logic signed [TW_BITS-1:0]  a_re;
      logic signed [TW_BITS-1:0]  a_im;
      logic signed [TW_BITS-1:0]  b_re;
      logic signed [TW_BITS-1:0]  b_im;
   } butterfly_req_type;

   typedef struct {
      logic signed [TW_BITS-1:0]  sum_re;
      logic signed [TW_BITS-1:0]  sum_im;
      logic signed [TW_BITS-1:0]  diff_re;
      logic signed [TW_BITS-1:0]  diff_im;
   } butterfly_rsp_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [BLOCK_BITS-1:0]      req_block_index;
   logic [PAIR_BITS-1:0]       req_pair_index;
   logic signed [TW_BITS-1:0]  req_a_re;
   logic signed [TW_BITS-1:0]  req_a_im;
   logic signed [TW_BITS-1:0]  req_b_re;
   logic signed [TW_BITS-1:0]  req_b_im;
   logic                       rsp_valid;
   logic signed [TW_BITS-1:0]  rsp_sum_re;
   logic signed [TW_BITS-1:0]  rsp_sum_im;
   logic signed [TW_BITS-1:0]  rsp_diff_re;
   logic signed [TW_BITS-1:0]  rsp_diff_im;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_BITS-1:0]   paddr;
   logic [CSR_DATA_BITS-1:0]   pwdata;
   logic [CSR_DATA_BITS-1:0]   prdata;
   logic                       pready;

   r2tb_pkg::cfg_type          cfg_shadow;
   butterfly_rsp_type          pending_results[$];
   int                         mismatch_count;
   int                         sent_count;
   int                         checked_count;
   int                         setting_count;
   int                         cycle_count;

   radix2_twiddle_butterfly_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_block_index (req_block_index),
      .req_pair_index  (req_pair_index),
      .req_a_re        (req_a_re),
      .req_a_im        (req_a_im),
      .req_b_re        (req_b_re),
      .req_b_im        (req_b_im),
      .rsp_valid       (rsp_valid),
      .rsp_sum_re      (rsp_sum_re),
      .rsp_sum_im      (rsp_sum_im),
      .rsp_diff_re     (rsp_diff_re),
      .rsp_diff_im     (rsp_diff_im),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // (a*b) >> 60 in q60
   function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[123:60];
   endfunction

   // cos and sin in q60 of 2*pi*u/65536 for u up to an eighth turn
   function automatic void trig_series(input logic [63:0] u, output logic [63:0] c,
                                       output logic [63:0] s);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] tc;
      logic [63:0] ts;
      x = u * (TWO_PI_Q60 >> 16) + ((u * (TWO_PI_Q60 & 64'hFFFF)) >> 16);
      x2 = mul_q60(x, x);
      tc = ONE_Q60;
      ts = x;
      c = tc;
      s = ts;
      for (int k = 1; k <= 12; k++) begin
         tc = mul_q60(tc, x2) / (64'(2 * k - 1) * 64'(2 * k));
         ts = mul_q60(ts, x2) / (64'(2 * k) * 64'(2 * k + 1));
         if (k % 2 == 1) begin
            c = c - tc;
            s = s - ts;
         end else begin
            c = c + tc;
            s = s + ts;
         end
      end
   endfunction

   // floor(0.5 + 32768.5*mag) with sign, clipped to 16 bits
   function automatic logic signed [TW_BITS-1:0] scale_q15(logic [63:0] mag, logic neg);
      logic [63:0] m44;
      longint      v;
      m44 = mag >> 16;
      v = longint'((64'd65537 * m44 + (64'd1 << 44)) >> 45);
      if (neg) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[TW_BITS-1:0];
   endfunction

   function automatic butterfly_rsp_type butterfly_predict(butterfly_req_type req);
      logic [63:0]       modulus;
      logic [63:0]       blk_offset;
      logic [63:0]       incr;
      logic [63:0]       rom_addr;
      logic [63:0]       u;
      logic [63:0]       c;
      logic [63:0]       s;
      logic              cneg;
      longint            w_re;
      longint            w_im;
      longint            b_re;
      longint            b_im;
      longint            a_re;
      longint            a_im;
      longint            prod_re;
      longint            prod_im;
      longint            acc;
      butterfly_rsp_type rsp;
      modulus = 64'(cfg_shadow.group_count) << cfg_shadow.stage;
      blk_offset = (modulus != 0) ?
         (64'(req.block_index) * 64'(cfg_shadow.pairs_per_block)) % modulus : 64'd0;
      incr = (64'(cfg_shadow.transform_len) >> (cfg_shadow.stage + 1)) & 64'hFFFF;
      rom_addr = (((blk_offset + 64'(req.pair_index)) * incr) & 64'hFFFF) %
                 r2tb_pkg::TWIDDLE_DEPTH_DEF;
      // rom entry from quarter-wave symmetry
      if (rom_addr <= 16384) begin
         u = rom_addr;
         cneg = 1'b0;
      end else begin
         u = 64'd32768 - rom_addr;
         cneg = 1'b1;
      end
      if (u <= 8192) trig_series(u, c, s);
      else trig_series(64'd16384 - u, s, c);
      w_re = scale_q15(c, cneg);
      w_im = scale_q15(s, 1'b1);
      a_re = req.a_re;
      a_im = req.a_im;
      b_re = req.b_re;
      b_im = req.b_im;
      prod_re = (b_re * w_re - b_im * w_im) >>> 15;
      prod_im = (b_re * w_im + b_im * w_re) >>> 15;
      // product wraps to sample width
      prod_re = longint'($signed(prod_re[TW_BITS-1:0]));
      prod_im = longint'($signed(prod_im[TW_BITS-1:0]));
      acc = (a_re + prod_re) >>> 1;
      rsp.sum_re = acc[TW_BITS-1:0];
      acc = (a_im + prod_im) >>> 1;
      rsp.sum_im = acc[TW_BITS-1:0];
      acc = (a_re - prod_re) >>> 1;
      rsp.diff_re = acc[TW_BITS-1:0];
      acc = (a_im - prod_im) >>> 1;
      rsp.diff_im = acc[TW_BITS-1:0];
      return rsp;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      butterfly_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", rsp_sum_re, 0);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_sum_re !== want.sum_re)
               report_mismatch("sum_re", rsp_sum_re, want.sum_re);
            if (rsp_sum_im !== want.sum_im)
               report_mismatch("sum_im", rsp_sum_im, want.sum_im);
            if (rsp_diff_re !== want.diff_re)
               report_mismatch("diff_re", rsp_diff_re, want.diff_re);
            if (rsp_diff_im !== want.diff_im)
               report_mismatch("diff_im", rsp_diff_im, want.diff_im);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("radix2_twiddle_butterfly_top: mismatch");
      $finish;
   end

   task automatic csr_write(r2tb_pkg::csr_reg_type which, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = CSR_ADDR_BITS'({which, 2'b00});
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         r2tb_pkg::REG_PAIRS:  cfg_shadow.pairs_per_block = value[PPB_BITS-1:0];
         r2tb_pkg::REG_STAGE:  cfg_shadow.stage = value[STAGE_BITS-1:0];
         r2tb_pkg::REG_GROUPS: cfg_shadow.group_count = value[GROUP_BITS-1:0];
         r2tb_pkg::REG_LEN:    cfg_shadow.transform_len = value[LEN_BITS-1:0];
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_check(r2tb_pkg::csr_reg_type which);
      logic [CSR_DATA_BITS-1:0] want;
      case (which)
         r2tb_pkg::REG_PAIRS:  want = CSR_DATA_BITS'(cfg_shadow.pairs_per_block);
         r2tb_pkg::REG_STAGE:  want = CSR_DATA_BITS'(cfg_shadow.stage);
         r2tb_pkg::REG_GROUPS: want = CSR_DATA_BITS'(cfg_shadow.group_count);
         default:              want = CSR_DATA_BITS'(cfg_shadow.transform_len);
      endcase
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = CSR_ADDR_BITS'({which, 2'b00});
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) report_mismatch(which.name(), prdata, want);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] pairs, logic [31:0] stg, logic [31:0] groups,
                                 logic [31:0] len);
      csr_write(r2tb_pkg::REG_PAIRS, pairs);
      csr_write(r2tb_pkg::REG_STAGE, stg);
      csr_write(r2tb_pkg::REG_GROUPS, groups);
      csr_write(r2tb_pkg::REG_LEN, len);
      csr_check(r2tb_pkg::REG_PAIRS);
      csr_check(r2tb_pkg::REG_STAGE);
      csr_check(r2tb_pkg::REG_GROUPS);
      csr_check(r2tb_pkg::REG_LEN);
      setting_count++;
   endtask

   function automatic logic signed [TW_BITS-1:0] edge_sample();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         default: return TW_BITS'($urandom_range(65535));
      endcase
   endfunction

   function automatic butterfly_req_type random_pair();
      butterfly_req_type req;
      req.block_index = BLOCK_BITS'($urandom_range(255));
      req.pair_index = PAIR_BITS'($urandom_range(32767));
      req.a_re = edge_sample();
      req.a_im = edge_sample();
      req.b_re = edge_sample();
      req.b_im = edge_sample();
      return req;
   endfunction

   function automatic butterfly_req_type make_pair(int blk, int k, int ar, int ai, int br,
                                                   int bi);
      butterfly_req_type req;
      req.block_index = BLOCK_BITS'(blk);
      req.pair_index = PAIR_BITS'(k);
      req.a_re = TW_BITS'(ar);
      req.a_im = TW_BITS'(ai);
      req.b_re = TW_BITS'(br);
      req.b_im = TW_BITS'(bi);
      return req;
   endfunction

   task automatic send_pair(butterfly_req_type req, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         // junk on the index fields, a_re and b_im while start is low
         req_block_index = BLOCK_BITS'($urandom);
         req_pair_index = PAIR_BITS'($urandom);
         req_a_re = TW_BITS'($urandom);
         req_b_im = TW_BITS'($urandom);
      end
      @(negedge clock);
      req_block_index = req.block_index;
      req_pair_index = req.pair_index;
      req_a_re = req.a_re;
      req_a_im = req.a_im;
      req_b_re = req.b_re;
      req_b_im = req.b_im;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(butterfly_predict(req));
      sent_count++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_values();
      csr_check(r2tb_pkg::REG_PAIRS);
      csr_check(r2tb_pkg::REG_STAGE);
      csr_check(r2tb_pkg::REG_GROUPS);
      csr_check(r2tb_pkg::REG_LEN);
      setting_count++;
   endtask

   // default settings give a stride of 2048, a sixteenth of the rom per step of k
   task automatic test_directed_corners();
      send_pair(make_pair(0, 0, 0, 0, 0, 0), 0);
      send_pair(make_pair(0, 0, 32767, 32767, 32767, 32767), 0);
      send_pair(make_pair(0, 0, -32768, -32768, -32768, -32768), 0);
      send_pair(make_pair(0, 0, 32767, -32768, -32768, 32767), 0);
      // product overflow at the -22.5 degree twiddle
      send_pair(make_pair(0, 2, 0, 0, -32768, 32767), 0);
      send_pair(make_pair(0, 2, 32767, -32768, 32767, -32768), 0);
      send_pair(make_pair(1, 1, -32768, 32767, -32768, 32767), 0);
      send_pair(make_pair(0, 4, 1000, -1000, 32767, 0), 0);
      send_pair(make_pair(0, 8, -1, 1, 12345, -23456), 0);
      send_pair(make_pair(0, 12, 32767, 32767, -32768, -32768), 0);
      send_pair(make_pair(0, 15, 5, -5, 30000, 30000), 0);
      // index past the rom wraps
      send_pair(make_pair(0, 16, 100, 200, 32767, -32768), 0);
      send_pair(make_pair(255, 32767, 32767, -32768, 32767, 32767), 0);
      send_pair(make_pair(128, 16383, -1, 1, -1, 1), 0);
      // pair position past pairs per block
      send_pair(make_pair(3, 5, 21845, -21846, -10923, 10922), 0);
      drain_results();
   endtask

   task automatic test_zero_group_count();
      csr_write(r2tb_pkg::REG_GROUPS, 32'd0);
      csr_check(r2tb_pkg::REG_GROUPS);
      setting_count++;
      send_pair(make_pair(7, 3, 1000, 2000, 3000, 4000), 0);
      send_pair(make_pair(255, 1, -32768, 32767, 32767, -32768), 0);
      send_pair(make_pair(0, 32767, 32767, 32767, -32768, -32768), 0);
      send_pair(make_pair(42, 9, -7, 7, 20000, -20000), 0);
      drain_results();
   endtask

   task automatic test_random_traffic();
      int idle_pct[6] = '{0, 76, 22, 0, 76, 22};
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(32'd3, 32'd2, 32'd5, 32'd1024);
            1: apply_settings(32'd65535, 32'd15, 32'd65535, 32'h1FFFF);
            2: apply_settings(32'd0, 32'd0, 32'd0, 32'd2);
            3: apply_settings(32'd32768, 32'd7, 32'd1, 32'd65536);
            4: apply_settings($urandom_range(32768, 1), $urandom_range(15),
                              $urandom_range(32768, 1), $urandom_range(65536, 2));
            default: apply_settings($urandom, $urandom, $urandom, $urandom);
         endcase
         for (int n = 0; n < 90; n++) send_pair(random_pair(), idle_pct[phase]);
         drain_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_block_index = '0;
      req_pair_index = '0;
      req_a_re = '0;
      req_a_im = '0;
      req_b_re = '0;
      req_b_im = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_shadow.pairs_per_block = PPB_BITS'(1);
      cfg_shadow.stage = STAGE_BITS'(0);
      cfg_shadow.group_count = GROUP_BITS'(2);
      cfg_shadow.transform_len = LEN_BITS'(4096);
      mismatch_count = 0;
      sent_count = 0;
      checked_count = 0;
      setting_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed_corners();
      test_zero_group_count();
      test_random_traffic();

      repeat (r2tb_pkg::TOTAL_LAT + 8) @(posedge clock);
      $display("covered %0d requests under %0d register settings, %0d results compared",
               sent_count, setting_count, checked_count);
      $display("idle patterns: back to back, 76 and 22 percent sender gaps");
      if (mismatch_count == 0) begin
         $display("radix2_twiddle_butterfly_top: match");
      end else begin
         $display("radix2_twiddle_butterfly_top: mismatch");
      end
      $finish;
   end

endmodule
